### rtl/core/ebs_pkg.sv
// Shared types, codes and helper functions for the EBML element header scanner.
// No dependencies; imported by every module of the block.
package ebs_pkg;

	// Width of the element limit register and of the header counter.
	localparam int LIMIT_W = 17;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 17'h10000;

	// Register index of the element limit.
	localparam logic REG_ELEMENT_LIMIT = 1'b0;

	// Parser phases.
	localparam logic [2:0] PH_ID_FIRST   = 3'd0;
	localparam logic [2:0] PH_ID_REST    = 3'd1;
	localparam logic [2:0] PH_SIZE_FIRST = 3'd2;
	localparam logic [2:0] PH_SIZE_REST  = 3'd3;
	localparam logic [2:0] PH_PAYLOAD    = 3'd4;

	// Result event codes.
	localparam logic [1:0] EV_TAKEN    = 2'd0;
	localparam logic [1:0] EV_COMPLETE = 2'd1;
	localparam logic [1:0] EV_PAYLOAD  = 2'd2;
	localparam logic [1:0] EV_ERROR    = 2'd3;

	// One result item, apart from the offset whose width is a parameter.
	typedef struct packed {
		logic [1:0]  event_res;
		logic [31:0] element_id;
		logic [55:0] element_size;
		logic        size_unknown;
		logic [7:0]  payload_byte;
	} ebs_result_t;

	// Leading zero bits of a byte before the first one, 0 to 8.
	function automatic logic [3:0] lead_zeros(input logic [7:0] b);
		logic [3:0] n;
		n = 4'd8;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				n = 4'(7 - i);
			end
		end
		return n;
	endfunction

	// Reserved all-ones value of a size field that is len bytes long.
	function automatic logic [55:0] size_all_ones(input logic [3:0] len);
		logic [55:0] v;
		unique case (len)
			4'd1:    v = 56'h7F;
			4'd2:    v = 56'h3FFF;
			4'd3:    v = 56'h1F_FFFF;
			4'd4:    v = 56'hFFF_FFFF;
			4'd5:    v = 56'h7_FFFF_FFFF;
			4'd6:    v = 56'h3FF_FFFF_FFFF;
			4'd7:    v = 56'h1_FFFF_FFFF_FFFF;
			default: v = 56'hFF_FFFF_FFFF_FFFF;
		endcase
		return v;
	endfunction

endpackage

### rtl/core/ebml_element_header_scanner_top.sv
// Top level of the EBML element header scanner: input register, parser core,
// result register and APB configuration. Depends on ebs_pkg, ebs_cfg, ebs_core.
//
//   channel   direction  handshake            payload
//   input     in         in_valid / in_stall  data_byte
//   output    out        out_valid/ out_stall event_res, element_id, element_size,
//                                             size_unknown, data_offset, payload_byte
//   config    in/out     APB psel/penable     paddr, pwdata, prdata
//
// One byte per clock is sustained while the output is not stalled; each byte
// gives exactly one result item. Each byte passes through the input register,
// then the parser decode into the result register. The parser state loop
// updates once per byte. A stalled output holds its result; the input register
// takes one more byte only if it is empty, then input stall follows output stall.
// Reset clears all parser state and sets the element limit to 65536.
module ebml_element_header_scanner_top
	import ebs_pkg::*;
#(
	parameter int OFFSET_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_stall,
	input  logic [7:0]             data_byte,
	output logic                   out_valid,
	input  logic                   out_stall,
	output logic [1:0]             event_res,
	output logic [31:0]            element_id,
	output logic [55:0]            element_size,
	output logic                   size_unknown,
	output logic [OFFSET_BITS-1:0] data_offset,
	output logic [7:0]             payload_byte,
	input  logic                   psel,
	input  logic                   penable,
	input  logic                   pwrite,
	input  logic [2:0]             paddr,
	input  logic [31:0]            pwdata,
	output logic [31:0]            prdata,
	output logic                   pready
);

	logic                   valid_s1;
	logic [7:0]             byte_s1;
	logic                   out_valid_q;
	ebs_result_t            res_q;
	logic [OFFSET_BITS-1:0] off_q;
	logic                   adv_out;
	logic                   step;
	logic [LIMIT_W-1:0]     element_limit;
	ebs_result_t            res_c;
	logic [OFFSET_BITS-1:0] off_c;

	// Pipeline control: the result register moves when empty or taken.
	assign adv_out  = !out_valid_q || !out_stall;
	assign step     = valid_s1 && adv_out;
	assign in_stall = valid_s1 && !adv_out;

	ebs_cfg u_cfg (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.element_limit (element_limit)
	);

	ebs_core #(
		.OFFSET_BITS (OFFSET_BITS)
	) u_core (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.data_byte     (byte_s1),
		.element_limit (element_limit),
		.result        (res_c),
		.data_offset   (off_c)
	);

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_out) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res_c;
			off_q <= off_c;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = res_q.event_res;
	assign element_id   = res_q.element_id;
	assign element_size = res_q.element_size;
	assign size_unknown = res_q.size_unknown;
	assign data_offset  = off_q;
	assign payload_byte = res_q.payload_byte;

endmodule

### rtl/core/ebs_cfg.sv
// APB register file of the scanner: holds the element limit register.
// Depends on ebs_pkg for the register index and reset value.
module ebs_cfg
	import ebs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [2:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output logic [LIMIT_W-1:0] element_limit
);

	logic [LIMIT_W-1:0] limit_q;
	logic               reg_idx;

	// Word index of the access; byte bits are ignored.
	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	// Register write on the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= LIMIT_RESET;
		end else if (psel && penable && pwrite && (reg_idx == REG_ELEMENT_LIMIT)) begin
			limit_q <= pwdata[LIMIT_W-1:0];
		end
	end

	// Read back; addresses beyond the register read as zero.
	always_comb begin
		prdata = '0;
		if (reg_idx == REG_ELEMENT_LIMIT) begin
			prdata = {{(32-LIMIT_W){1'b0}}, limit_q};
		end
	end

	assign element_limit = limit_q;

endmodule

### rtl/core/ebs_core.sv
// Parser state and next-state logic of the scanner: one byte per step.
// Depends on ebs_pkg for phases, event codes and decode helpers.
module ebs_core
	import ebs_pkg::*;
#(
	parameter int OFFSET_BITS = 48
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   step,
	input  logic [7:0]             data_byte,
	input  logic [LIMIT_W-1:0]     element_limit,
	output ebs_result_t            result,
	output logic [OFFSET_BITS-1:0] data_offset
);

	logic [2:0]             phase_q, phase_n;
	logic [3:0]             fbl_q, fbl_n;
	logic [3:0]             slen_q, slen_n;
	logic [31:0]            id_q, id_n;
	logic [55:0]            sacc_q, sacc_n;
	logic [55:0]            rem_q, rem_n;
	logic [OFFSET_BITS-1:0] pos_q, pos_n;
	logic [LIMIT_W-1:0]     hc_q, hc_n;
	logic                   err_q, err_n;
	logic [3:0]             lz;
	logic                   err_now;
	logic                   complete;

	assign lz    = lead_zeros(data_byte);
	assign pos_n = pos_q + 1'b1;

	// Decode of one byte against the current phase.
	always_comb begin
		phase_n  = phase_q;
		fbl_n    = fbl_q;
		slen_n   = slen_q;
		id_n     = id_q;
		sacc_n   = sacc_q;
		rem_n    = rem_q;
		hc_n     = hc_q;
		err_now  = 1'b0;
		complete = 1'b0;
		result   = '0;
		result.event_res = EV_TAKEN;
		data_offset = '0;

		if (!err_q) begin
			unique case (phase_q)
				PH_ID_FIRST: begin
					if ((hc_q >= element_limit) || (lz > 4'd3)) begin
						err_now = 1'b1;
					end else begin
						if (hc_q != {LIMIT_W{1'b1}}) begin
							hc_n = hc_q + 1'b1;
						end
						id_n    = {24'd0, data_byte};
						fbl_n   = lz;
						phase_n = (lz != 4'd0) ? PH_ID_REST : PH_SIZE_FIRST;
					end
				end
				PH_ID_REST: begin
					id_n = {id_q[23:0], data_byte};
					if (fbl_q != 4'd0) begin
						fbl_n = fbl_q - 1'b1;
					end
					if (fbl_n == 4'd0) begin
						phase_n = PH_SIZE_FIRST;
					end
				end
				PH_SIZE_FIRST: begin
					if (lz == 4'd8) begin
						err_now = 1'b1;
					end else begin
						slen_n = lz + 1'b1;
						sacc_n = {48'd0, data_byte & (8'h7F >> lz)};
						fbl_n  = lz;
						if (lz == 4'd0) begin
							complete = 1'b1;
						end else begin
							phase_n = PH_SIZE_REST;
						end
					end
				end
				PH_SIZE_REST: begin
					sacc_n = {sacc_q[47:0], data_byte};
					if (fbl_q != 4'd0) begin
						fbl_n = fbl_q - 1'b1;
					end
					if (fbl_n == 4'd0) begin
						complete = 1'b1;
					end
				end
				PH_PAYLOAD: begin
					result.event_res    = EV_PAYLOAD;
					result.payload_byte = data_byte;
					if (rem_q != 56'd0) begin
						rem_n = rem_q - 1'b1;
					end
					if (rem_n == 56'd0) begin
						phase_n = PH_ID_FIRST;
					end
				end
				default: begin
					phase_n = PH_ID_FIRST;
				end
			endcase
		end

		err_n = err_q | err_now;

		// Error overrides everything; a finished header reports its fields.
		if (err_n) begin
			result = '0;
			result.event_res = EV_ERROR;
		end else if (complete) begin
			result.event_res    = EV_COMPLETE;
			result.element_id   = id_n;
			result.element_size = sacc_n;
			result.size_unknown = (sacc_n == size_all_ones(slen_n));
			data_offset         = pos_n;
			if (result.size_unknown || (sacc_n == 56'd0)) begin
				phase_n = PH_ID_FIRST;
			end else begin
				rem_n   = sacc_n;
				phase_n = PH_PAYLOAD;
			end
		end
	end

	// State update on each accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_ID_FIRST;
			fbl_q   <= '0;
			slen_q  <= '0;
			id_q    <= '0;
			sacc_q  <= '0;
			rem_q   <= '0;
			pos_q   <= '0;
			hc_q    <= '0;
			err_q   <= 1'b0;
		end else if (step) begin
			phase_q <= phase_n;
			fbl_q   <= fbl_n;
			slen_q  <= slen_n;
			id_q    <= id_n;
			sacc_q  <= sacc_n;
			rem_q   <= rem_n;
			pos_q   <= pos_n;
			hc_q    <= hc_n;
			err_q   <= err_n;
		end
	end

endmodule

### rtl/core/ebs_checker.sv
// Port-level checks of the scanner's result channel, bound to the top level.
// Depends on ebs_pkg for event codes and on ebml_element_header_scanner_top.
module ebs_checker
	import ebs_pkg::*;
#(
	parameter int OFFSET_BITS = 48
) (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   out_valid,
	input logic                   out_stall,
	input logic [1:0]             event_res,
	input logic [31:0]            element_id,
	input logic [55:0]            element_size,
	input logic                   size_unknown,
	input logic [OFFSET_BITS-1:0] data_offset,
	input logic [7:0]             payload_byte
);

	logic err_seen_q;

	// Remember that an error item was delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_seen_q <= 1'b0;
		end else if (out_valid && !out_stall && (event_res == EV_ERROR)) begin
			err_seen_q <= 1'b1;
		end
	end

	// Header fields are zero in every item other than header complete.
	a_hdr_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res != EV_COMPLETE)) |->
		((element_id == 32'd0) && (element_size == 56'd0) &&
		 !size_unknown && (data_offset == '0)))
		else $error("header fields set outside header complete");

	// The payload byte is zero except on payload items.
	a_pay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (event_res != EV_PAYLOAD)) |-> (payload_byte == 8'd0))
		else $error("payload byte set outside payload item");

	// Once an error was delivered, every later item is an error.
	a_err_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && err_seen_q) |-> (event_res == EV_ERROR))
		else $error("error did not stay latched");

	// An unknown size is never a zero size.
	a_unk_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && size_unknown) |-> (element_size != 56'd0))
		else $error("unknown size flagged on zero size");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_res) &&
		 $stable(element_size)))
		else $error("stalled result changed");

endmodule

bind ebml_element_header_scanner_top ebs_checker #(
	.OFFSET_BITS (OFFSET_BITS)
) u_ebs_checker (.*);
